// ----- hw/rtl/cnp_pkg.sv -----
// Shared constants, types and neighbour offsets of the cellular noise pixel block.
`timescale 1ns / 1ps
`default_nettype none

package cnp_pkg;

    localparam int MAX_GRID   = 64;
    localparam int GRID_BITS  = 6;
    localparam int TAB_DEPTH  = MAX_GRID * MAX_GRID;
    localparam int TAB_AW     = 2 * GRID_BITS;
    localparam int TAB_W      = 48;
    localparam int MAX_IMAGE  = 4096;
    localparam int FRAC_BITS  = 16;
    localparam int APB_AW     = 5;
    localparam int DIV_STEPS  = 28;
    localparam int SQRT_STEPS = 18;
    localparam int NB_COUNT   = 9;

    localparam logic signed [19:0] ONE     = 20'sh10000;
    localparam logic signed [19:0] P_LIMIT = 20'sh40000;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        REG_IMAGE_SIZE = 3'd0,
        REG_GRID_CELLS = 3'd1,
        REG_COMBINE    = 3'd2,
        REG_METRIC     = 3'd3,
        REG_MOSAIC     = 3'd4,
        REG_SHINE      = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        CMB_F1          = 3'd0,
        CMB_ONE_MINUS_F1 = 3'd1,
        CMB_F2          = 3'd2,
        CMB_F2_MINUS_F1 = 3'd3,
        CMB_NORM        = 3'd4,
        CMB_ONE_MINUS_NORM = 3'd5
    } combine_t;

    typedef enum logic [1:0] {
        MET_EUCLID    = 2'd0,
        MET_MANHATTAN = 2'd1,
        MET_CHEBYSHEV = 2'd2
    } metric_t;

    typedef enum logic [1:0] {
        MOS_NONE  = 2'd0,
        MOS_FLAT  = 2'd1,
        MOS_SHINY = 2'd2
    } mosaic_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_DIVN,
        S_RD,
        S_AB,
        S_MD,
        S_SQA,
        S_SQB,
        S_SUM,
        S_SQRT,
        S_UPD,
        S_COMB,
        S_MOSAIC,
        S_POW,
        S_POWS,
        S_WMUL,
        S_WFIN,
        S_OUT
    } state_t;

    // visit order: centre first, then the ring
    function automatic logic signed [1:0] nb_dx(input logic [3:0] idx);
        logic signed [1:0] r;
        begin
            case (idx)
                4'd1, 4'd4, 4'd6: r = -2'sd1;
                4'd3, 4'd5, 4'd8: r = 2'sd1;
                default:          r = 2'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [1:0] nb_dy(input logic [3:0] idx);
        logic signed [1:0] r;
        begin
            case (idx)
                4'd1, 4'd2, 4'd3: r = 2'sd1;
                4'd6, 4'd7, 4'd8: r = -2'sd1;
                default:          r = 2'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cellular_noise_pixel.sv -----
// Top level of the cellular (F1/F2) noise pixel block.
`timescale 1ns / 1ps
`default_nettype none

// Cellular noise, one Q1.15 value per pixel beat. Load beats write one cell of
// the 64x64 feature table (x, y, weight) and give no result; table entries
// hold garbage until written. A pixel beat runs alone: nine bit-serial
// divisions (pitch, cell index and in-cell fraction on each axis, a turnaround
// state after each), then nine table reads through the one read port, each
// followed by its distance step: direct for Manhattan or Chebyshev, and for
// Euclidean two squares on the shared 20x20 multiplier and an 18-step square
// root. Norm combines reuse the squares and the square root, and shiny mosaic
// takes one multiply per exponent step and one for the weight. The result sits
// in an output register, so the next beat is taken while it waits.
module cellular_noise_pixel
    import cnp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 opcode,
    input  wire logic [5:0]           cell_col,
    input  wire logic [5:0]           cell_row,
    input  wire logic [15:0]          feature_x,
    input  wire logic [15:0]          feature_y,
    input  wire logic [15:0]          cell_weight,
    input  wire logic [11:0]          pixel_x,
    input  wire logic [11:0]          pixel_y,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [15:0]        noise_value,
    output logic [11:0]               out_x,
    output logic [11:0]               out_y,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // configuration
    logic [12:0] image_size_reg;
    logic [6:0]  grid_cells_reg;
    logic [2:0]  combine_mode_reg;
    logic [1:0]  metric_reg;
    logic [1:0]  mosaic_mode_reg;
    logic [3:0]  shine_exponent_reg;
    logic        cfg_wr;

    logic [6:0]  g_c;
    logic [12:0] s_c;
    logic [5:0]  gm1;

    state_t state_reg, state_next;

    logic [11:0] px_reg, px_next, py_reg, py_next;
    logic [12:0] pitch_reg, pitch_next;
    logic [5:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [15:0] fx_reg, fx_next, fy_reg, fy_next;

    logic [3:0]  div_idx_reg, div_idx_next;
    logic [27:0] div_num_reg, div_num_next;
    logic [12:0] div_den_reg, div_den_next;
    logic [13:0] div_rem_reg, div_rem_next;
    logic [27:0] div_q_reg, div_q_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;

    logic [3:0]  ld_idx;
    logic [11:0] ld_p;
    logic [18:0] ld_pg;
    logic [27:0] ld_num;
    logic [12:0] ld_den;

    logic [13:0] div_sh;
    logic        div_ge;
    logic [13:0] div_rem_step;

    logic [3:0]  nb_idx_reg, nb_idx_next;
    logic signed [17:0] a_reg, a_next, b_reg, b_next;
    logic [15:0] w_reg, w_next;
    logic [17:0] d_reg, d_next;
    logic [17:0] f1_reg, f1_next, f2_reg, f2_next;
    logic [15:0] w1_reg, w1_next;
    logic        comb_reg, comb_next;

    logic signed [39:0] prod_reg, prod_next, acc_reg, acc_next;
    logic signed [19:0] mul_a, mul_b;
    logic signed [40:0] sq_sum;

    logic [35:0] sq_rad_reg, sq_rad_next;
    logic [18:0] sq_rem_reg, sq_rem_next;
    logic [17:0] sq_root_reg, sq_root_next;
    logic [4:0]  sq_cnt_reg, sq_cnt_next;
    logic [20:0] sq_sh, sq_trial;
    logic        sq_ge;
    logic [20:0] sq_rem_step;
    logic [17:0] sq_root_step;

    logic signed [19:0] v_reg, v_next, p_reg, p_next;
    logic [3:0]  e_cnt_reg, e_cnt_next;
    logic signed [23:0] prod_q;

    logic        out_valid_reg, out_valid_next;
    logic signed [15:0] noise_reg, noise_next;
    logic [11:0] ox_reg, ox_next, oy_reg, oy_next;
    logic signed [20:0] t_val;

    // table access
    logic                ram_wr_en;
    logic [TAB_AW-1:0]   ram_wr_addr;
    logic [TAB_W-1:0]    ram_wr_data;
    logic                ram_rd_en;
    logic [TAB_AW-1:0]   ram_rd_addr;
    logic [TAB_W-1:0]    ram_rd_data;
    logic signed [1:0]   dx, dy;
    logic [5:0]          nx, ny;
    logic signed [17:0]  a_base, b_base;
    logic [17:0]         abs_a, abs_b;
    logic [18:0]         man_sum;
    logic                in_acc, is_euclid;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg     <= 13'd256;
            grid_cells_reg     <= 7'd8;
            combine_mode_reg   <= CMB_F1;
            metric_reg         <= MET_EUCLID;
            mosaic_mode_reg    <= MOS_NONE;
            shine_exponent_reg <= 4'd1;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_IMAGE_SIZE: image_size_reg     <= pwdata[12:0];
                REG_GRID_CELLS: grid_cells_reg     <= pwdata[6:0];
                REG_COMBINE:    combine_mode_reg   <= pwdata[2:0];
                REG_METRIC:     metric_reg         <= pwdata[1:0];
                REG_MOSAIC:     mosaic_mode_reg    <= pwdata[1:0];
                REG_SHINE:      shine_exponent_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_IMAGE_SIZE: prdata = {19'd0, image_size_reg};
            REG_GRID_CELLS: prdata = {25'd0, grid_cells_reg};
            REG_COMBINE:    prdata = {29'd0, combine_mode_reg};
            REG_METRIC:     prdata = {30'd0, metric_reg};
            REG_MOSAIC:     prdata = {30'd0, mosaic_mode_reg};
            REG_SHINE:      prdata = {28'd0, shine_exponent_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // clamped grid and image size
    always_comb
    begin
        if (grid_cells_reg == 7'd0)
            g_c = 7'd1;
        else if (grid_cells_reg > 7'(MAX_GRID))
            g_c = 7'(MAX_GRID);
        else
            g_c = grid_cells_reg;
        if (image_size_reg == 13'd0)
            s_c = 13'd1;
        else if (image_size_reg > 13'(MAX_IMAGE))
            s_c = 13'(MAX_IMAGE);
        else
            s_c = image_size_reg;
        gm1 = 6'(g_c - 7'd1);
    end

    assign is_euclid = (metric_reg != MET_MANHATTAN) && (metric_reg != MET_CHEBYSHEV);

    cnp_ram #(
        .WIDTH (TAB_W),
        .DEPTH (TAB_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ram_wr_en   = in_acc && (opcode == OP_LOAD);
    assign ram_wr_addr = {cell_col, cell_row};
    assign ram_wr_data = {feature_x, feature_y, cell_weight};
    assign ram_rd_en   = (state_reg == S_RD);
    assign ram_rd_addr = {nx, ny};

    // wrapped neighbour cell
    always_comb
    begin
        dx = nb_dx(nb_idx_reg);
        dy = nb_dy(nb_idx_reg);
        case (dx)
            -2'sd1:  nx = (cx_reg == 6'd0) ? gm1 : cx_reg - 6'd1;
            2'sd1:   nx = (cx_reg == gm1) ? 6'd0 : cx_reg + 6'd1;
            default: nx = cx_reg;
        endcase
        case (dy)
            -2'sd1:  ny = (cy_reg == 6'd0) ? gm1 : cy_reg - 6'd1;
            2'sd1:   ny = (cy_reg == gm1) ? 6'd0 : cy_reg + 6'd1;
            default: ny = cy_reg;
        endcase
    end

    // offset vector to the feature point, Q2.16
    always_comb
    begin
        a_base = $signed({2'b00, ram_rd_data[47:32]}) - $signed({2'b00, fx_reg});
        b_base = $signed({2'b00, ram_rd_data[31:16]}) - $signed({2'b00, fy_reg});
        case (dx)
            -2'sd1:  a_next = a_base - 18'sh10000;
            2'sd1:   a_next = a_base + 18'sh10000;
            default: a_next = a_base;
        endcase
        case (dy)
            -2'sd1:  b_next = b_base - 18'sh10000;
            2'sd1:   b_next = b_base + 18'sh10000;
            default: b_next = b_base;
        endcase
        abs_a   = a_reg[17] ? 18'(-a_reg) : 18'(a_reg);
        abs_b   = b_reg[17] ? 18'(-b_reg) : 18'(b_reg);
        man_sum = {1'b0, abs_a} + {1'b0, abs_b};
    end

    // divide operand loader: pitch, cell and fraction per axis
    always_comb
    begin
        ld_idx = (state_reg == S_IDLE) ? 4'd0 : div_idx_reg + 4'd1;
        ld_p   = (ld_idx < 4'd5) ? px_reg : py_reg;
        ld_pg  = {7'd0, ld_p} * {12'd0, g_c};
        case (ld_idx)
            4'd0:
            begin
                ld_num = {15'd0, s_c};
                ld_den = {6'd0, g_c};
            end
            4'd1, 4'd5:
            begin
                ld_num = {9'd0, ld_pg};
                ld_den = s_c;
            end
            4'd2, 4'd6:
            begin
                ld_num = div_q_reg;
                ld_den = {6'd0, g_c};
            end
            4'd3, 4'd7:
            begin
                ld_num = {16'd0, ld_p};
                ld_den = pitch_reg;
            end
            default:
            begin
                ld_num = {div_rem_reg[11:0], 16'd0};
                ld_den = pitch_reg;
            end
        endcase
    end

    // one restoring divide step and one square-root step per cycle
    always_comb
    begin
        div_sh       = {div_rem_reg[12:0], div_num_reg[27]};
        div_ge       = (div_sh >= {1'b0, div_den_reg});
        div_rem_step = div_ge ? div_sh - {1'b0, div_den_reg} : div_sh;

        sq_sh        = {sq_rem_reg, sq_rad_reg[35:34]};
        sq_trial     = {1'b0, sq_root_reg, 2'b01};
        sq_ge        = (sq_sh >= sq_trial);
        sq_rem_step  = sq_ge ? sq_sh - sq_trial : sq_sh;
        sq_root_step = {sq_root_reg[16:0], sq_ge};
    end

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            S_SQA:
            begin
                mul_a = comb_reg ? $signed({2'b00, f1_reg}) : 20'(a_reg);
                mul_b = mul_a;
            end
            S_SQB:
            begin
                mul_a = comb_reg ? $signed({2'b00, f2_reg}) : 20'(b_reg);
                mul_b = mul_a;
            end
            S_POW:
            begin
                mul_a = p_reg;
                mul_b = v_reg;
            end
            S_WMUL:
            begin
                mul_a = p_reg;
                mul_b = $signed({4'd0, w1_reg});
            end
            default:
            begin
                mul_a = 20'sd0;
                mul_b = 20'sd0;
            end
        endcase
        prod_next = mul_a * mul_b;
        sq_sum    = 41'(acc_reg) + 41'(prod_reg);
        prod_q    = prod_reg[FRAC_BITS+23:FRAC_BITS];
        t_val     = 21'(v_reg) - 21'sd32768;
    end

    always_comb
    begin
        state_next     = state_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pitch_next     = pitch_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        div_idx_next   = div_idx_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_q_next     = div_q_reg;
        div_cnt_next   = div_cnt_reg;
        nb_idx_next    = nb_idx_reg;
        w_next         = w_reg;
        d_next         = d_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        w1_next        = w1_reg;
        comb_next      = comb_reg;
        acc_next       = acc_reg;
        sq_rad_next    = sq_rad_reg;
        sq_rem_next    = sq_rem_reg;
        sq_root_next   = sq_root_reg;
        sq_cnt_next    = sq_cnt_reg;
        v_next         = v_reg;
        p_next         = p_reg;
        e_cnt_next     = e_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        noise_next     = noise_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (opcode == OP_PIXEL))
                begin
                    px_next      = pixel_x;
                    py_next      = pixel_y;
                    div_idx_next = 4'd0;
                    div_num_next = ld_num;
                    div_den_next = ld_den;
                    div_rem_next = 14'd0;
                    div_cnt_next = 5'd0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                div_rem_next = div_rem_step;
                div_q_next   = {div_q_reg[26:0], div_ge};
                div_num_next = {div_num_reg[26:0], 1'b0};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'(DIV_STEPS - 1))
                    state_next = S_DIVN;
            end
            S_DIVN:
            begin
                case (div_idx_reg)
                    4'd0: pitch_next = (div_q_reg == 28'd0) ? 13'd1 : div_q_reg[12:0];
                    4'd2: cx_next = div_rem_reg[5:0];
                    4'd4: fx_next = div_q_reg[15:0];
                    4'd6: cy_next = div_rem_reg[5:0];
                    4'd8: fy_next = div_q_reg[15:0];
                    default: ;
                endcase
                if (div_idx_reg == 4'(NB_COUNT - 1))
                begin
                    nb_idx_next = 4'd0;
                    f1_next     = '1;
                    f2_next     = '1;
                    w1_next     = 16'd0;
                    comb_next   = 1'b0;
                    state_next  = S_RD;
                end
                else
                begin
                    div_idx_next = ld_idx;
                    div_num_next = ld_num;
                    div_den_next = ld_den;
                    div_rem_next = 14'd0;
                    div_cnt_next = 5'd0;
                    state_next   = S_DIV;
                end
            end
            S_RD:
            begin
                state_next = S_AB;
            end
            S_AB:
            begin
                w_next     = ram_rd_data[15:0];
                state_next = is_euclid ? S_SQA : S_MD;
            end
            S_MD:
            begin
                if (metric_reg == MET_MANHATTAN)
                    d_next = man_sum[18:1];
                else
                    d_next = (abs_a > abs_b) ? abs_a : abs_b;
                state_next = S_UPD;
            end
            S_SQA:
            begin
                state_next = S_SQB;
            end
            S_SQB:
            begin
                acc_next   = prod_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sq_rad_next  = sq_sum[36:1];
                sq_rem_next  = 19'd0;
                sq_root_next = 18'd0;
                sq_cnt_next  = 5'd0;
                state_next   = S_SQRT;
            end
            S_SQRT:
            begin
                sq_rem_next  = sq_rem_step[18:0];
                sq_root_next = sq_root_step;
                sq_rad_next  = {sq_rad_reg[33:0], 2'b00};
                sq_cnt_next  = sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    if (comb_reg)
                    begin
                        if (combine_mode_reg == CMB_NORM)
                            v_next = $signed({2'b00, sq_root_step});
                        else
                            v_next = ONE - $signed({2'b00, sq_root_step});
                        state_next = S_MOSAIC;
                    end
                    else
                    begin
                        d_next     = sq_root_step;
                        state_next = S_UPD;
                    end
                end
            end
            S_UPD:
            begin
                // strictly smaller only: ties keep the earlier cell
                if (d_reg < f1_reg)
                begin
                    f2_next = f1_reg;
                    f1_next = d_reg;
                    w1_next = w_reg;
                end
                else if (d_reg < f2_reg)
                begin
                    f2_next = d_reg;
                end
                nb_idx_next = nb_idx_reg + 4'd1;
                state_next  = (nb_idx_reg == 4'(NB_COUNT - 1)) ? S_COMB : S_RD;
            end
            S_COMB:
            begin
                state_next = S_MOSAIC;
                case (combine_mode_reg)
                    CMB_ONE_MINUS_F1:   v_next = ONE - $signed({2'b00, f1_reg});
                    CMB_F2:             v_next = $signed({2'b00, f2_reg});
                    CMB_F2_MINUS_F1:    v_next = $signed({2'b00, f2_reg})
                                               - $signed({2'b00, f1_reg});
                    CMB_NORM, CMB_ONE_MINUS_NORM:
                    begin
                        comb_next  = 1'b1;
                        state_next = S_SQA;
                    end
                    default:            v_next = $signed({2'b00, f1_reg});
                endcase
            end
            S_MOSAIC:
            begin
                case (mosaic_mode_reg)
                    MOS_FLAT:
                    begin
                        v_next     = $signed({4'd0, w1_reg});
                        state_next = S_OUT;
                    end
                    MOS_SHINY:
                    begin
                        p_next     = ONE;
                        e_cnt_next = 4'd0;
                        state_next = (shine_exponent_reg == 4'd0) ? S_WMUL : S_POW;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_POW:
            begin
                state_next = S_POWS;
            end
            S_POWS:
            begin
                if (prod_q > 24'(P_LIMIT))
                    p_next = P_LIMIT;
                else if (prod_q < -24'(P_LIMIT))
                    p_next = -P_LIMIT;
                else
                    p_next = prod_q[19:0];
                e_cnt_next = e_cnt_reg + 4'd1;
                state_next = (e_cnt_reg + 4'd1 == shine_exponent_reg) ? S_WMUL : S_POW;
            end
            S_WMUL:
            begin
                state_next = S_WFIN;
            end
            S_WFIN:
            begin
                v_next     = prod_q[19:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // 2v-1 in Q1.15 reduces to v - 0.5 in Q4.16 units
                if (!out_valid_reg || !out_stall)
                begin
                    if (t_val > 21'sd32767)
                        noise_next = 16'sh7FFF;
                    else if (t_val < -21'sd32768)
                        noise_next = -16'sh8000;
                    else
                        noise_next = t_val[15:0];
                    ox_next        = px_reg;
                    oy_next        = py_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        pitch_reg   <= pitch_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        div_idx_reg <= div_idx_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        div_cnt_reg <= div_cnt_next;
        nb_idx_reg  <= nb_idx_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        w_reg       <= w_next;
        d_reg       <= d_next;
        f1_reg      <= f1_next;
        f2_reg      <= f2_next;
        w1_reg      <= w1_next;
        comb_reg    <= comb_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        sq_rad_reg  <= sq_rad_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        sq_cnt_reg  <= sq_cnt_next;
        v_reg       <= v_next;
        p_reg       <= p_next;
        e_cnt_reg   <= e_cnt_next;
        noise_reg   <= noise_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cnp_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module cnp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cnp_checker.sv -----
// Port-level checker for the cellular noise pixel block and its bind.
`timescale 1ns / 1ps
`default_nettype none

module cnp_checker
    import cnp_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               opcode,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [15:0] noise_value,
    input wire logic [11:0]        out_x,
    input wire logic [11:0]        out_y
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(noise_value) && $stable(out_x) && $stable(out_y))
        else $error("stalled result beat changed");

    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_PIXEL) |=> in_stall)
        else $error("pixel beat did not occupy the block");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_LOAD) && !out_valid |=> !out_valid)
        else $error("load beat produced a result");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a pixel in flight");

endmodule

bind cellular_noise_pixel cnp_checker u_cnp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value),
    .out_x       (out_x),
    .out_y       (out_y)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for the cellular noise pixel block: self-checking, random and directed beats.
`timescale 1ns / 1ps

module tb_top;
    import cnp_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;
    localparam int DRAIN_WAIT  = 600;

    typedef struct packed {
        logic signed [15:0] noise;
        logic [11:0]        x;
        logic [11:0]        y;
    } pixel_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = OP_LOAD;
    logic [5:0] cell_col = '0;
    logic [5:0] cell_row = '0;
    logic [15:0] feature_x = '0;
    logic [15:0] feature_y = '0;
    logic [15:0] cell_weight = '0;
    logic [11:0] pixel_x = '0;
    logic [11:0] pixel_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] noise_value;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cellular_noise_pixel i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .cell_col(cell_col), .cell_row(cell_row),
        .feature_x(feature_x), .feature_y(feature_y), .cell_weight(cell_weight),
        .pixel_x(pixel_x), .pixel_y(pixel_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .noise_value(noise_value), .out_x(out_x), .out_y(out_y),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mirror of the block's registers and feature table
    logic [12:0] cfg_size    = 13'd256;
    logic [6:0]  cfg_grid    = 7'd8;
    logic [2:0]  cfg_combine = CMB_F1;
    logic [1:0]  cfg_metric  = MET_EUCLID;
    logic [1:0]  cfg_mosaic  = MOS_NONE;
    logic [3:0]  cfg_shine   = 4'd1;
    logic [15:0] feat_x_tab [TAB_DEPTH];
    logic [15:0] feat_y_tab [TAB_DEPTH];
    logic [15:0] feat_w_tab [TAB_DEPTH];
    bit          cell_written [TAB_DEPTH];

    pixel_result_t expected_pixels [$];
    int errors = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int hold_left = 0;
    int items_sent = 0;
    longint cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        pixel_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                report("unexpected beat x", out_x, -1);
            else
            begin
                e = expected_pixels.pop_front();
                if (noise_value !== e.noise) report("noise_value", noise_value, e.noise);
                if (out_x !== e.x) report("out_x", out_x, e.x);
                if (out_y !== e.y) report("out_y", out_y, e.y);
            end
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint half_norm(input longint a, input longint b);
        longint unsigned s;
        s = a * a + b * b;
        return longint'(int_sqrt(s >> 1));
    endfunction

    function automatic longint abs_l(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint feature_dist(input longint a, input longint b);
        longint aa, ab;
        aa = abs_l(a);
        ab = abs_l(b);
        if (cfg_metric == MET_MANHATTAN) return (aa + ab) >>> 1;
        if (cfg_metric == MET_CHEBYSHEV) return aa > ab ? aa : ab;
        return half_norm(a, b);
    endfunction

    function automatic int eff_grid();
        if (cfg_grid < 1) return 1;
        if (cfg_grid > MAX_GRID) return MAX_GRID;
        return cfg_grid;
    endfunction

    function automatic longint nb_ofs_x(input int i);
        case (i)
            1, 4, 6: return -1;
            3, 5, 8: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint nb_ofs_y(input int i);
        case (i)
            1, 2, 3: return 1;
            6, 7, 8: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic longint cell_of(input logic [11:0] p);
        longint g, s;
        g = eff_grid();
        s = cfg_size < 1 ? 1 : (cfg_size > MAX_IMAGE ? MAX_IMAGE : cfg_size);
        return (p * g / s) % g;
    endfunction

    function automatic pixel_result_t predict_noise(input logic [11:0] px, input logic [11:0] py);
        longint g, s, pitch, cx, cy, fx, fy, f1, f2, w1, v, p, t, nx, ny, a, b, d, one;
        int k;
        pixel_result_t r;
        one = 64'd1 << FRAC_BITS;
        g = eff_grid();
        s = cfg_size < 1 ? 1 : (cfg_size > MAX_IMAGE ? MAX_IMAGE : cfg_size);
        pitch = s / g;
        if (pitch < 1) pitch = 1;
        cx = (px * g / s) % g;
        cy = (py * g / s) % g;
        fx = ((px % pitch) << FRAC_BITS) / pitch;
        fy = ((py % pitch) << FRAC_BITS) / pitch;
        f1 = 64'h7FFF_FFFF_FFFF_FFFF;
        f2 = f1;
        w1 = 0;
        for (int i = 0; i < NB_COUNT; i++)
        begin
            nx = cx + nb_ofs_x(i);
            ny = cy + nb_ofs_y(i);
            if (nx < 0) nx = g - 1;
            if (ny < 0) ny = g - 1;
            nx = nx % g;
            ny = ny % g;
            k = int'(nx * MAX_GRID + ny);
            a = longint'(feat_x_tab[k]) + nb_ofs_x(i) * one - fx;
            b = longint'(feat_y_tab[k]) + nb_ofs_y(i) * one - fy;
            d = feature_dist(a, b);
            if (d < f1)
            begin
                f2 = f1;
                f1 = d;
                w1 = feat_w_tab[k];
            end
            else if (d < f2)
                f2 = d;
        end
        case (cfg_combine)
            CMB_ONE_MINUS_F1:   v = one - f1;
            CMB_F2:             v = f2;
            CMB_F2_MINUS_F1:    v = f2 - f1;
            CMB_NORM:           v = half_norm(f1, f2);
            CMB_ONE_MINUS_NORM: v = one - half_norm(f1, f2);
            default:            v = f1;
        endcase
        if (cfg_mosaic == MOS_FLAT)
            v = w1;
        else if (cfg_mosaic == MOS_SHINY)
        begin
            p = one;
            for (int e = 0; e < cfg_shine; e++)
            begin
                p = (p * v) >>> FRAC_BITS;
                if (p > 4 * one) p = 4 * one;
                if (p < -4 * one) p = -4 * one;
            end
            v = (p * w1) >>> FRAC_BITS;
        end
        t = (2 * v - one) >>> (FRAC_BITS - 15);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        r.noise = t[15:0];
        r.x = px;
        r.y = py;
        return r;
    endfunction

    // one input beat; holds valid across back-to-back beats
    task automatic send_beat(input opcode_t op, input logic [5:0] col, input logic [5:0] row,
                             input logic [15:0] fx, input logic [15:0] fy,
                             input logic [15:0] w, input logic [11:0] px,
                             input logic [11:0] py);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < in_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        cell_col <= col;
        cell_row <= row;
        feature_x <= fx;
        feature_y <= fy;
        cell_weight <= w;
        pixel_x <= px;
        pixel_y <= py;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (op == OP_LOAD)
        begin
            feat_x_tab[col * MAX_GRID + row] = fx;
            feat_y_tab[col * MAX_GRID + row] = fy;
            feat_w_tab[col * MAX_GRID + row] = w;
            cell_written[col * MAX_GRID + row] = 1'b1;
        end
        else
            expected_pixels.push_back(predict_noise(px, py));
    endtask

    task automatic load_cell(input logic [5:0] col, input logic [5:0] row);
        send_beat(OP_LOAD, col, row, 16'($urandom), 16'($urandom), 16'($urandom),
                  12'($urandom), 12'($urandom));
    endtask

    // the pixel's 3x3 neighbourhood is written before the pixel beat reads it
    task automatic cover_cells(input logic [11:0] px, input logic [11:0] py);
        longint g, cx, cy, nx, ny;
        g = eff_grid();
        cx = cell_of(px);
        cy = cell_of(py);
        for (int i = 0; i < NB_COUNT; i++)
        begin
            nx = cx + nb_ofs_x(i);
            ny = cy + nb_ofs_y(i);
            if (nx < 0) nx = g - 1;
            if (ny < 0) ny = g - 1;
            nx = nx % g;
            ny = ny % g;
            if (!cell_written[int'(nx * MAX_GRID + ny)])
                load_cell(6'(nx), 6'(ny));
        end
    endtask

    task automatic pixel_beat(input logic [11:0] px, input logic [11:0] py);
        cover_cells(px, py);
        send_beat(OP_PIXEL, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), px, py);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= APB_AW'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_IMAGE_SIZE: cfg_size = val[12:0];
            REG_GRID_CELLS: cfg_grid = val[6:0];
            REG_COMBINE:    cfg_combine = val[2:0];
            REG_METRIC:     cfg_metric = val[1:0];
            REG_MOSAIC:     cfg_mosaic = val[1:0];
            default:        cfg_shine = val[3:0];
        endcase
    endtask

    task automatic set_all(input int size, input int grid, input int cmb, input int met,
                           input int mos, input int shine);
        go_idle();
        write_reg(REG_IMAGE_SIZE, size);
        write_reg(REG_GRID_CELLS, grid);
        write_reg(REG_COMBINE, cmb);
        write_reg(REG_METRIC, met);
        write_reg(REG_MOSAIC, mos);
        write_reg(REG_SHINE, shine);
    endtask

    // every cell the current grid can read gets written first
    task automatic fill_grid();
        int g;
        g = eff_grid();
        for (int c = 0; c < g; c++)
            for (int r = 0; r < g; r++)
                load_cell(6'(c), 6'(r));
    endtask

    task automatic test_reset_defaults();
        fill_grid();
        pixel_beat(0, 0);
        pixel_beat(4095, 4095);
        pixel_beat(31, 32);
    endtask

    task automatic test_directed();
        // ties: identical features everywhere
        set_all(64, 4, CMB_F2_MINUS_F1, MET_CHEBYSHEV, MOS_FLAT, 0);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                send_beat(OP_LOAD, 6'(c), 6'(r), 16'h8000, 16'h8000, 16'(c * 4 + r) << 12,
                          0, 0);
        pixel_beat(8, 8);
        pixel_beat(0, 63);
        // feature extremes, sizes and grids out of range
        set_all(0, 0, CMB_ONE_MINUS_F1, MET_EUCLID, MOS_SHINY, 15);
        send_beat(OP_LOAD, 0, 0, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 0);
        pixel_beat(0, 4095);
        set_all(8191, 127, CMB_NORM, MET_MANHATTAN, MOS_NONE, 1);
        send_beat(OP_LOAD, 63, 63, 16'hFFFF, 16'hFFFF, 16'h0000, 0, 0);
        pixel_beat(4095, 0);
        pixel_beat(2048, 4095);
        // every combine, including unused selectors with metric 3 and mosaic 3
        for (int m = 0; m < 8; m++)
        begin
            set_all(96, 3, m, m % 4, m % 4, m * 2 + 1);
            pixel_beat(12'($urandom_range(4095)), 12'($urandom_range(4095)));
        end
    endtask

    task automatic random_phase(input int beats, input int in_pct, input int out_pct);
        int g;
        int stop;
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        stop = items_sent + beats;
        while (items_sent < stop)
        begin
            g = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 6);
            set_all(($urandom_range(3) == 0) ? $urandom_range(8191)
                                             : g * $urandom_range(1, 64),
                    g, $urandom_range(7), $urandom_range(3), $urandom_range(3),
                    $urandom_range(15));
            for (int k = 0; k < 60 && items_sent < stop; k++)
            begin
                if ($urandom_range(99) < 35)
                    load_cell(6'($urandom), 6'($urandom));
                else
                    pixel_beat(12'($urandom), 12'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        in_idle_pct = 0;
        out_idle_pct = 0;
        go_idle();
        hold_left = 3000;
        for (int k = 0; k < 8; k++)
            pixel_beat(12'($urandom), 12'($urandom));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        random_phase(580, 21, 64);
        random_phase(580, 64, 21);
        test_backpressure();
        random_phase(580, 0, 0);
        go_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
